>>> src/tlds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlds_pkg: shared types and codes of the driver sequencer
// Item function codes, register indexes, phase encoding and the structs that
// pass configuration and results between modules.
// ----------------------------------------------------------------------------
package tlds_pkg;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_TICK   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    REG_FILTER_ALPHA   = 3'd0,
    REG_MIN_OPEN_SECS  = 3'd1,
    REG_MIN_CLOSE_SECS = 3'd2,
    REG_MAX_SECS       = 3'd3,
    REG_OPEN_RELEASE   = 3'd4,
    REG_CLOSE_TORQUE   = 3'd5,
    REG_CLOSE_HOLD     = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    DRIVE_STOP  = 2'd0,
    DRIVE_OPEN  = 2'd1,
    DRIVE_CLOSE = 2'd2
  } drive_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_DRIVE = 3'b010,
    PH_HOLD  = 3'b100
  } phase_t;

  localparam int unsigned ElapsedMax = 255;

  typedef struct packed {
    logic        [15:0] filter_alpha;
    logic        [7:0]  min_open_secs;
    logic        [7:0]  min_close_secs;
    logic        [7:0]  max_secs;
    logic signed [31:0] open_release_level;
    logic signed [31:0] close_torque_level;
    logic        [3:0]  close_hold_secs;
  } cfg_t;

  typedef struct packed {
    logic        [1:0]  drive_command;
    logic signed [31:0] filtered_effort;
    logic               done_res;
    logic               busy_res;
  } result_t;

endpackage : tlds_pkg
`default_nettype wire

>>> src/torque_limited_driver_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// torque_limited_driver_sequencer_top: screwdriver drive sequencer
// Runs an open or close sequence from start, sample and tick items and
// reports drive command, filtered effort, done and busy for every item.
// ----------------------------------------------------------------------------
// Each input transfer yields exactly one result transfer. The block takes one
// item per clock cycle while back-pressure does not stall it. An item is held
// in the input register, and its result is then offered from the result
// register (one input register, one result register). The state update for an
// item, including the two filter multiplies, is done combinationally in the
// path between those registers, so that the next item sees the updated average at
// once. Back-pressure on the result side stalls the input register only when
// the result register is full and not being taken. Configuration writes take
// effect at the next clock edge and are meant to be made only while no item
// is in flight.
// ----------------------------------------------------------------------------
module torque_limited_driver_sequencer_top
  import tlds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_we,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [31:0] cfg_data,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [1:0]  func,
  input  wire logic               open_request,
  input  wire logic signed [31:0] effort_sample,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [1:0]  drive_command,
  output logic signed      [31:0] filtered_effort,
  output logic                    done_res,
  output logic                    busy_res
);

  cfg_t               cfg;
  logic               s1_valid;
  logic        [1:0]  s1_func;
  logic               s1_open;
  logic signed [31:0] s1_sample;
  logic               s1_go;
  result_t            result;
  result_t            res_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_alpha       <= 16'd62259;
      cfg.min_open_secs      <= 8'd20;
      cfg.min_close_secs     <= 8'd20;
      cfg.max_secs           <= 8'd35;
      cfg.open_release_level <= -32'sd249037;
      cfg.close_torque_level <= 32'sd622592;
      cfg.close_hold_secs    <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_ALPHA:   cfg.filter_alpha       <= cfg_data[15:0];
        REG_MIN_OPEN_SECS:  cfg.min_open_secs      <= cfg_data[7:0];
        REG_MIN_CLOSE_SECS: cfg.min_close_secs     <= cfg_data[7:0];
        REG_MAX_SECS:       cfg.max_secs           <= cfg_data[7:0];
        REG_OPEN_RELEASE:   cfg.open_release_level <= $signed(cfg_data);
        REG_CLOSE_TORQUE:   cfg.close_torque_level <= $signed(cfg_data);
        REG_CLOSE_HOLD:     cfg.close_hold_secs    <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // advance the input register whenever the result register can take a value
  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // hold the payload of the accepted transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func   <= func;
      s1_open   <= open_request;
      s1_sample <= effort_sample;
    end
  end

  // state update happens only when the item moves on into the result register
  tlds_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .step          (s1_go),
    .func          (s1_func),
    .open_request  (s1_open),
    .effort_sample (s1_sample),
    .result        (result)
  );

  // result register: drop valid once the transfer is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res_q <= result;
    end
  end

  assign drive_command   = res_q.drive_command;
  assign filtered_effort = res_q.filtered_effort;
  assign done_res        = res_q.done_res;
  assign busy_res        = res_q.busy_res;

endmodule : torque_limited_driver_sequencer_top
`default_nettype wire

>>> src/tlds_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlds_filter: exponential moving average update
// avg' = floor((avg*alpha + x*(65536-alpha) + 32768) / 65536), Q16.16.
// ----------------------------------------------------------------------------
module tlds_filter
  import tlds_pkg::*;
(
  input  wire logic        [15:0] alpha,
  input  wire logic signed [31:0] avg,
  input  wire logic signed [31:0] sample,
  output logic signed      [31:0] avg_next
);

  logic signed [17:0] w_old;
  logic signed [17:0] w_new;
  logic signed [49:0] p_old;
  logic signed [49:0] p_new;
  logic signed [49:0] sum;

  assign w_old = $signed({2'b00, alpha});
  assign w_new = $signed(18'h10000 - {2'b00, alpha});

  // two parallel products, one rounding add
  assign p_old = 50'(avg) * 50'(w_old);
  assign p_new = 50'(sample) * 50'(w_new);
  assign sum   = p_old + p_new + 50'sd32768;

  // floor shift by 16; the magnitude stays within 32 bits
  assign avg_next = sum[47:16];

endmodule : tlds_filter
`default_nettype wire

>>> src/tlds_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlds_seq: run state and per-item step
// Holds phase, direction, elapsed and hold counters and the effort average,
// and forms the result of each item from the updated state.
// ----------------------------------------------------------------------------
module tlds_seq
  import tlds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               step,
  input  wire logic        [1:0]  func,
  input  wire logic               open_request,
  input  wire logic signed [31:0] effort_sample,
  output result_t                 result
);

  phase_t             phase, phase_next;
  logic               opening_dir, opening_dir_next;
  logic        [7:0]  elapsed_ticks, elapsed_ticks_next;
  logic        [3:0]  hold_ticks, hold_ticks_next;
  logic signed [31:0] effort_average, effort_average_next;
  logic signed [31:0] avg_filt;
  logic               done;
  logic        [7:0]  tmin;
  logic               crossed;
  logic               keep;

  tlds_filter u_filter (
    .alpha    (cfg.filter_alpha),
    .avg      (effort_average),
    .sample   (effort_sample),
    .avg_next (avg_filt)
  );

  always_comb begin
    phase_next          = phase;
    opening_dir_next    = opening_dir;
    elapsed_ticks_next  = elapsed_ticks;
    hold_ticks_next     = hold_ticks;
    effort_average_next = effort_average;
    done                = 1'b0;
    tmin                = 8'd0;
    crossed             = 1'b0;
    keep                = 1'b0;
    case (func)
      FUNC_START: begin
        opening_dir_next    = open_request;
        effort_average_next = '0;
        elapsed_ticks_next  = '0;
        hold_ticks_next     = '0;
        phase_next          = PH_DRIVE;
      end
      FUNC_SAMPLE: begin
        if (phase != PH_IDLE) begin
          effort_average_next = avg_filt;
        end
      end
      FUNC_TICK: begin
        if (phase == PH_DRIVE) begin
          if (elapsed_ticks != 8'(ElapsedMax)) begin
            elapsed_ticks_next = elapsed_ticks + 8'd1;
          end
          tmin    = opening_dir ? cfg.min_open_secs : cfg.min_close_secs;
          crossed = opening_dir ? (effort_average <= cfg.open_release_level)
                                : (effort_average >= cfg.close_torque_level);
          keep    = (elapsed_ticks_next < tmin) ||
                    ((elapsed_ticks_next < cfg.max_secs) && !crossed);
          if (!keep) begin
            if (opening_dir || cfg.close_hold_secs == 4'd0) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end else begin
              phase_next      = PH_HOLD;
              hold_ticks_next = '0;
            end
          end
        end else if (phase == PH_HOLD) begin
          hold_ticks_next = hold_ticks + 4'd1;
          if (hold_ticks_next >= cfg.close_hold_secs) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (phase_next == PH_IDLE) begin
      result.drive_command = DRIVE_STOP;
    end else begin
      result.drive_command = opening_dir_next ? DRIVE_OPEN : DRIVE_CLOSE;
    end
    result.filtered_effort = effort_average_next;
    result.done_res        = done;
    result.busy_res        = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      opening_dir    <= 1'b0;
      elapsed_ticks  <= '0;
      hold_ticks     <= '0;
      effort_average <= '0;
    end else if (step) begin
      phase          <= phase_next;
      opening_dir    <= opening_dir_next;
      elapsed_ticks  <= elapsed_ticks_next;
      hold_ticks     <= hold_ticks_next;
      effort_average <= effort_average_next;
    end
  end

endmodule : tlds_seq
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the torque-limited driver sequencer
// Drives start, effort sample and tick items through the valid/ready input
// channel, predicts each result with a cycle-free model of the sequencer and
// checks every result transfer field by field, in order, under varied
// register settings and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import tlds_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int         CycleLimit = 400000;
  localparam int         DrainLimit = 2000;
  localparam int         BlockItems = 90;
  localparam int         ReportCap = 100;
  localparam longint     EffortMax = 64'sd2147483647;
  localparam longint     EffortMin = -64'sd2147483648;

  typedef enum {CFG_SMALL, CFG_FLOOR, CFG_POWER_ON, CFG_CEILING} cfg_kind_t;

  // --------------------------------------------------------------------------
  // Sequencer model and store of pending results
  // --------------------------------------------------------------------------
  class sequencer_scoreboard;
    cfg_t               cfg;
    phase_t             phase;
    logic               opening;
    logic        [7:0]  elapsed;
    logic        [3:0]  hold;
    logic signed [31:0] average;
    result_t            pending_results[$];

    function new();
      cfg = '{filter_alpha: 16'd62259, min_open_secs: 8'd20, min_close_secs: 8'd20,
              max_secs: 8'd35, open_release_level: -32'sd249037,
              close_torque_level: 32'sd622592, close_hold_secs: 4'd8};
      phase   = PH_IDLE;
      opening = 1'b0;
      elapsed = '0;
      hold    = '0;
      average = '0;
    endfunction

    function void write_reg(reg_index_t idx, logic [31:0] value);
      case (idx)
        REG_FILTER_ALPHA:   cfg.filter_alpha       = value[15:0];
        REG_MIN_OPEN_SECS:  cfg.min_open_secs      = value[7:0];
        REG_MIN_CLOSE_SECS: cfg.min_close_secs     = value[7:0];
        REG_MAX_SECS:       cfg.max_secs           = value[7:0];
        REG_OPEN_RELEASE:   cfg.open_release_level = value;
        REG_CLOSE_TORQUE:   cfg.close_torque_level = value;
        REG_CLOSE_HOLD:     cfg.close_hold_secs    = value[3:0];
        default: ;
      endcase
    endfunction

    // Moving average with round-half-up: floor((sum + 2^15) / 2^16).
    function logic signed [31:0] smoothed(logic signed [31:0] x);
      longint weight;
      longint sum;
      weight = longint'(cfg.filter_alpha);
      sum = longint'(average) * weight + longint'(x) * (64'sd65536 - weight) + 64'sd32768;
      return sum[47:16];
    endfunction

    function bit keep_driving();
      logic [7:0] min_ticks;
      bit         crossed;
      min_ticks = opening ? cfg.min_open_secs : cfg.min_close_secs;
      crossed = opening ? ($signed(average) <= $signed(cfg.open_release_level))
                        : ($signed(average) >= $signed(cfg.close_torque_level));
      if (elapsed < min_ticks) return 1'b1;
      return (elapsed < cfg.max_secs) && !crossed;
    endfunction

    // Note an accepted input transfer and queue the result it causes.
    function void note_item(logic [1:0] f, logic open_req, logic signed [31:0] x);
      result_t res;
      logic    done;
      done = 1'b0;
      case (f)
        FUNC_START: begin
          opening = open_req;
          average = '0;
          elapsed = '0;
          hold    = '0;
          phase   = PH_DRIVE;
        end
        FUNC_SAMPLE: begin
          if (phase != PH_IDLE) average = smoothed(x);
        end
        FUNC_TICK: begin
          if (phase == PH_DRIVE) begin
            if (elapsed != 8'hFF) elapsed = elapsed + 8'd1;
            if (!keep_driving()) begin
              if (opening || cfg.close_hold_secs == 4'd0) begin
                phase = PH_IDLE;
                done  = 1'b1;
              end else begin
                phase = PH_HOLD;
                hold  = '0;
              end
            end
          end else if (phase == PH_HOLD) begin
            hold = hold + 4'd1;
            if (hold >= cfg.close_hold_secs) begin
              phase = PH_IDLE;
              done  = 1'b1;
            end
          end
        end
        default: ;
      endcase
      res.drive_command   = (phase == PH_IDLE) ? DRIVE_STOP
                          : (opening ? DRIVE_OPEN : DRIVE_CLOSE);
      res.filtered_effort = average;
      res.done_res        = done;
      res.busy_res        = (phase != PH_IDLE);
      pending_results.push_back(res);
    endfunction

    // Compare a result transfer with the oldest pending result.
    function bit check_result(result_t got, output string msg);
      result_t want;
      msg = "";
      if (pending_results.size() == 0) begin
        msg = $sformatf("result with nothing pending: drive %0d effort %h done %b busy %b",
                        got.drive_command, got.filtered_effort, got.done_res, got.busy_res);
        return 1'b0;
      end
      want = pending_results.pop_front();
      if (got.drive_command !== want.drive_command)
        msg = {msg, $sformatf(" drive_command %0d/%0d", got.drive_command, want.drive_command)};
      if (got.filtered_effort !== want.filtered_effort)
        msg = {msg, $sformatf(" filtered_effort %h/%h", got.filtered_effort,
                              want.filtered_effort)};
      if (got.done_res !== want.done_res)
        msg = {msg, $sformatf(" done_res %b/%b", got.done_res, want.done_res)};
      if (got.busy_res !== want.busy_res)
        msg = {msg, $sformatf(" busy_res %b/%b", got.busy_res, want.busy_res)};
      if (msg == "") return 1'b1;
      msg = {"result mismatch (got/want):", msg};
      return 1'b0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic        [2:0]  cfg_index = '0;
  logic        [31:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic        [1:0]  func = '0;
  logic               open_request = 1'b0;
  logic signed [31:0] effort_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic        [1:0]  drive_command;
  logic signed [31:0] filtered_effort;
  logic               done_res;
  logic               busy_res;

  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 58;
  int unsigned items_sent = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  sequencer_scoreboard model;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  torque_limited_driver_sequencer_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .open_request   (open_request),
    .effort_sample  (effort_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive_command  (drive_command),
    .filtered_effort(filtered_effort),
    .done_res       (done_res),
    .busy_res       (busy_res)
  );

  // Count each failure; print only the first ReportCap so a broken block cannot
  // flood the log.
  task automatic report(string msg);
    errors++;
    if (errors <= ReportCap) $display("[%0t] ERROR %s", $time, msg);
  endtask

  // Stall the result channel at random; the rate follows the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check every result transfer at the rising edge where it happens.
  always @(posedge clk) begin
    result_t got;
    string   msg;
    if (!rst && out_valid && out_ready) begin
      got = '{drive_command: drive_command, filtered_effort: filtered_effort,
              done_res: done_res, busy_res: busy_res};
      if (!model.check_result(got, msg)) report(msg);
    end
  end

  // Hard stop in case the block hangs or drops a handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------

  // Offer one item and hold it until the transfer. Gaps before the item
  // carry junk payload with valid low. Valid is left high on return so that
  // a following item goes out back to back; whoever idles drops it.
  task automatic send_item(logic [1:0] f, logic open_req, logic signed [31:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid      <= 1'b0;
      func          <= 2'($urandom);
      open_request  <= 1'($urandom);
      effort_sample <= $urandom;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    func          <= f;
    open_request  <= open_req;
    effort_sample <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model.note_item(f, open_req, x);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every pending result has been taken, then
  // let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (model.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all seven registers, one per cycle. Unused upper data bits carry
  // junk, which the block must drop.
  task automatic program_config(cfg_t c);
    reg_index_t  idx;
    logic [31:0] value;
    idx = idx.first();
    do begin
      value = $urandom;
      case (idx)
        REG_FILTER_ALPHA:   value[15:0] = c.filter_alpha;
        REG_MIN_OPEN_SECS:  value[7:0]  = c.min_open_secs;
        REG_MIN_CLOSE_SECS: value[7:0]  = c.min_close_secs;
        REG_MAX_SECS:       value[7:0]  = c.max_secs;
        REG_OPEN_RELEASE:   value       = c.open_release_level;
        REG_CLOSE_TORQUE:   value       = c.close_torque_level;
        REG_CLOSE_HOLD:     value[3:0]  = c.close_hold_secs;
        default: ;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= value;
      model.write_reg(idx, value);
      @(negedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t pick_config(cfg_kind_t kind);
    cfg_t c;
    case (kind)
      CFG_FLOOR:
        c = '{filter_alpha: 16'd0, min_open_secs: 8'd0, min_close_secs: 8'd0,
              max_secs: 8'd0, open_release_level: 32'sh8000_0000,
              close_torque_level: 32'sh7FFF_FFFF, close_hold_secs: 4'd0};
      CFG_POWER_ON:
        c = '{filter_alpha: 16'd62259, min_open_secs: 8'd20, min_close_secs: 8'd20,
              max_secs: 8'd35, open_release_level: -32'sd249037,
              close_torque_level: 32'sd622592, close_hold_secs: 4'd8};
      // Opening must run the full 255 ticks; closing crosses at once and
      // holds for the longest time.
      CFG_CEILING:
        c = '{filter_alpha: 16'hFFFF, min_open_secs: 8'd255, min_close_secs: 8'd0,
              max_secs: 8'd255, open_release_level: 32'sh7FFF_FFFF,
              close_torque_level: 32'sh8000_0000, close_hold_secs: 4'd15};
      default: begin
        case ($urandom_range(3))
          0:       c.filter_alpha = 16'd0;
          1:       c.filter_alpha = 16'hFFFF;
          default: c.filter_alpha = 16'($urandom_range(65535));
        endcase
        c.min_open_secs      = 8'($urandom_range(6));
        c.min_close_secs     = 8'($urandom_range(6));
        c.max_secs           = 8'($urandom_range(12));
        c.open_release_level = -32'sd1 * 32'($urandom_range(8 << 16));
        c.close_torque_level = 32'($urandom_range(12 << 16));
        if ($urandom_range(4) == 0) c.open_release_level = $urandom;
        if ($urandom_range(4) == 0) c.close_torque_level = $urandom;
        c.close_hold_secs    = 4'($urandom_range(15));
      end
    endcase
    return c;
  endfunction

  // Effort near the level that ends the current run, with some full-range
  // values and the extremes mixed in.
  function automatic logic signed [31:0] pick_effort();
    longint level;
    longint v;
    level = model.opening ? longint'($signed(model.cfg.open_release_level))
                          : longint'($signed(model.cfg.close_torque_level));
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return 32'sh7FFF_FFFF;
      3:       return 32'sh8000_0000;
      default: begin
        v = level + longint'($urandom_range(393216)) - 64'sd196608;
        if (v > EffortMax) v = EffortMax;
        if (v < EffortMin) v = EffortMin;
        return v[31:0];
      end
    endcase
  endfunction

  // One run: a start, then samples and ticks until the run ends, with the
  // odd unused code or restart thrown in; then a little idle noise.
  task automatic drive_run(int unsigned tick_pct);
    int unsigned steps;
    int unsigned r;
    steps = 0;
    send_item(FUNC_START, 1'($urandom), $urandom);
    while (model.phase != PH_IDLE && steps < 800) begin
      r = $urandom_range(99);
      if (r < 2)
        send_item(FuncUnused, 1'($urandom), $urandom);
      else if (r == 2 && tick_pct < 60)
        send_item(FUNC_START, 1'($urandom), $urandom);
      else if (r < 3 + tick_pct)
        send_item(FUNC_TICK, 1'($urandom), $urandom);
      else
        send_item(FUNC_SAMPLE, 1'($urandom), pick_effort());
      steps++;
    end
    repeat ($urandom_range(2))
      send_item(2'($urandom_range(FUNC_SAMPLE, FuncUnused)), 1'($urandom), $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t        c;
    cfg_kind_t   kind;
    int unsigned block_start;
    int unsigned guard;

    model = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Idle items under the power-on settings: each must leave state alone.
    send_item(FUNC_SAMPLE, 1'b1, 32'sh7FFF_FFFF);
    send_item(FUNC_TICK, 1'b0, 32'sh0);
    send_item(FuncUnused, 1'b1, 32'sh8000_0000);

    // Fast settings: the average follows the last sample exactly.
    drain();
    program_config('{filter_alpha: 16'd0, min_open_secs: 8'd1, min_close_secs: 8'd1,
                     max_secs: 8'd2, open_release_level: -32'sd65536,
                     close_torque_level: 32'sd65536, close_hold_secs: 4'd0});
    // Close with no hold: stops on the tick that fails the condition.
    send_item(FUNC_START, 1'b0, 32'sh0);
    send_item(FUNC_SAMPLE, 1'b0, 32'sh7FFF_FFFF);
    send_item(FUNC_TICK, 1'b0, 32'sh0);
    // Open at the most negative effort; unused code mid-run.
    send_item(FUNC_START, 1'b1, 32'sh0);
    send_item(FUNC_SAMPLE, 1'b1, 32'sh8000_0000);
    send_item(FuncUnused, 1'b0, 32'sh0);
    send_item(FUNC_TICK, 1'b1, 32'sh0);
    // Restart while busy, then run out the time limit.
    send_item(FUNC_START, 1'b0, 32'sh0);
    send_item(FUNC_SAMPLE, 1'b0, 32'sh0);
    send_item(FUNC_START, 1'b1, 32'sh0);
    send_item(FUNC_TICK, 1'b0, 32'sh0);
    send_item(FUNC_TICK, 1'b0, 32'sh0);

    // Slow filter; closing crosses at once and holds for two ticks.
    drain();
    program_config('{filter_alpha: 16'hFFFF, min_open_secs: 8'd1, min_close_secs: 8'd0,
                     max_secs: 8'd255, open_release_level: -32'sd65536,
                     close_torque_level: 32'sh8000_0000, close_hold_secs: 4'd2});
    send_item(FUNC_START, 1'b0, 32'sh0);
    send_item(FUNC_SAMPLE, 1'b0, 32'sh7FFF_FFFF);
    send_item(FUNC_SAMPLE, 1'b0, 32'sh8000_0000);
    send_item(FUNC_TICK, 1'b0, 32'sh0);
    send_item(FUNC_TICK, 1'b0, 32'sh0);
    send_item(FUNC_TICK, 1'b0, 32'sh0);
    send_item(FUNC_SAMPLE, 1'b1, 32'sh1234_5678);
    send_item(FUNC_TICK, 1'b1, 32'sh0);

    // Random runs in blocks: slow receiver first, then slow sender, then
    // both at full rate. Reprogram only once the block is drained.
    for (int blk = 0; blk < 9; blk++) begin
      send_idle_pct = (blk < 3) ? 17 : (blk < 6) ? 58 : 0;
      recv_idle_pct = (blk < 3) ? 58 : (blk < 6) ? 17 : 0;
      kind = (blk == 0) ? CFG_FLOOR
           : (blk == 2 || blk == 7) ? CFG_POWER_ON
           : (blk == 4) ? CFG_CEILING : CFG_SMALL;
      c = pick_config(kind);
      drain();
      program_config(c);
      block_start = items_sent;
      while (items_sent - block_start < BlockItems)
        drive_run((kind == CFG_CEILING) ? 80 : 45);
    end

    // Let the last results arrive, bounded, then give the verdict.
    in_valid <= 1'b0;
    guard = 0;
    while (model.pending() != 0 && guard < DrainLimit) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);
    if (model.pending() != 0)
      report($sformatf("%0d results never arrived", model.pending()));
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
